// ----- src/rcc_pkg.sv -----
// Package for the reservation conflict checker: item structs, codes and
// register indexes. No dependencies.
`timescale 1ns / 1ps

package rcc_pkg;

  localparam logic [1:0] MODE_RESERVE = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_FIND    = 2'd2;
  localparam logic [1:0] MODE_COUNT   = 2'd3;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_VERTEX = 2'd1;
  localparam logic [1:0] KIND_GOAL   = 2'd2;
  localparam logic [1:0] KIND_EDGE   = 2'd3;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_STEPS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_FINISHED = 2'd1;
  localparam logic [3:0] HOLD_STEPS_RESET = 4'd5;

  typedef struct packed {
    logic [1:0] mode;
    logic [4:0] agent;
    logic [7:0] location;
    logic [7:0] next_location;
    logic       next_present;
    logic [6:0] step_time;
    logic       malfunction;
    logic       path_end;
    logic [2:0] delay_window;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] first_agent;
    logic [4:0] second_agent;
    logic [7:0] conflict_location;
    logic [7:0] edge_location;
    logic [7:0] conflict_time;
    logic [2:0] delay;
  } res_entry_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] first_agent;
    logic [4:0] second_agent;
    logic [7:0] conflict_location;
    logic [7:0] edge_location;
    logic [7:0] conflict_time;
    logic [2:0] delay;
    logic [7:0] conflict_count;
    logic       overflow;
    logic       last;
  } out_item_t;

endpackage

// ----- src/rcc_stream_if.sv -----
// Valid/ready stream interface carrying one payload struct per transaction.
// Payload types come from rcc_pkg.
`timescale 1ns / 1ps

interface rcc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/rcc_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
// Standalone; used for the tables and the result buffer.
`timescale 1ns / 1ps

module rcc_ram #(
  parameter int DW = 8,
  parameter int DEPTH = 16,
  parameter int ADW = 4
) (
  input  logic           clk,
  input  logic           we,
  input  logic [ADW-1:0] waddr,
  input  logic [DW-1:0]  wdata,
  input  logic [ADW-1:0] raddr,
  output logic [DW-1:0]  rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/reservation_conflict_check.sv -----
// Reservation conflict checker top: sequencer over occupancy and agent_place RAMs, goal
// records, result buffer. Uses rcc_pkg, rcc_stream_if, rcc_ram.
// A reserve reads and writes one mark per step (1 + hold marks), a release reads and
// clears its mark, an out-of-range step is dropped. A query reads each window slot in
// horizon, walks each vertex hit and the AGENTS goal records (find), checks each occupant
// (zero delay), then sends each stored result; output can stall. One transaction in flight.
// Reset (sync) clears max(LOCATIONS, AGENTS) * HORIZON entries first; regs reset to 5 and 0.
`timescale 1ns / 1ps

module reservation_conflict_check #(
  parameter int AGENTS = 32,
  parameter int LOCATIONS = 256,
  parameter int HORIZON = 128,
  parameter int MAX_RESULTS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  rcc_stream_if.sink                    req,
  rcc_stream_if.source                  rsp,
  input  logic                          wr_en,
  input  logic [rcc_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [rcc_pkg::CFG_DATA_W-1:0] wr_data
);

  localparam int AW = $clog2(AGENTS);
  localparam int OCC_D = LOCATIONS * HORIZON;
  localparam int OCC_AW = $clog2(OCC_D);
  localparam int PL_D = AGENTS * HORIZON;
  localparam int PL_AW = $clog2(PL_D);
  localparam int CLR_D = (OCC_D > PL_D) ? OCC_D : PL_D;
  localparam int CLW = $clog2(CLR_D);
  localparam int RW = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
  localparam int CW = $clog2(MAX_RESULTS + 1);
  localparam int RES_W = $bits(rcc_pkg::res_entry_t);

  typedef enum logic [16:0] {
    S_CLEAR = 17'h00001,
    S_IDLE  = 17'h00002,
    S_MRD   = 17'h00004,
    S_MWR   = 17'h00008,
    S_RLRD  = 17'h00010,
    S_RLWR  = 17'h00020,
    S_VRD   = 17'h00040,
    S_VCHK  = 17'h00080,
    S_VSCAN = 17'h00100,
    S_GSCAN = 17'h00200,
    S_ERD   = 17'h00400,
    S_ECHK  = 17'h00800,
    S_EPRD  = 17'h01000,
    S_EPCHK = 17'h02000,
    S_FIN   = 17'h04000,
    S_OUTRD = 17'h08000,
    S_OUTLD = 17'h10000
  } state_t;

  state_t state;
  logic [CLW-1:0] clr;
  logic [3:0] hold_steps;
  logic ignore_finished;
  rcc_pkg::in_item_t q;
  logic [7:0] mtime;
  logic [3:0] mleft;
  logic signed [3:0] koff;
  logic [AGENTS-1:0] scan_mask;
  logic [AW-1:0] ga;
  logic [AW-1:0] ea;
  logic [7:0] count;
  logic [CW-1:0] wr_ptr;
  logic [CW-1:0] rd_ptr;
  logic over;
  logic goal_valid [AGENTS];
  logic [7:0] goal_loc [AGENTS];
  logic [6:0] goal_time [AGENTS];
  rcc_pkg::out_item_t out_q;
  logic out_v;

  logic occ_we, pl_we, res_we;
  logic [OCC_AW-1:0] occ_waddr, occ_raddr;
  logic [AGENTS-1:0] occ_wdata, occ_rdata;
  logic [PL_AW-1:0] pl_waddr, pl_raddr;
  logic [8:0] pl_wdata, pl_rdata;
  logic [RES_W-1:0] res_rdata;
  rcc_pkg::res_entry_t emit_e;
  logic emit_hit;

  logic acc, out_free, out_load, is_find, k_last, edge_go, place_match;
  logic [7:0] nt;
  logic signed [10:0] ts;
  logic ts_ok;
  logic [AW-1:0] low;
  logic [AGENTS-1:0] abit;

  function automatic logic [OCC_AW-1:0] occ_addr(input logic [7:0] l, input logic [9:0] tm);
    occ_addr = OCC_AW'(int'(l) * HORIZON + int'(tm));
  endfunction

  function automatic logic [PL_AW-1:0] pl_addr(input logic [AW-1:0] a, input logic [9:0] tm);
    pl_addr = PL_AW'(int'(a) * HORIZON + int'(tm));
  endfunction

  assign acc = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_v;
  assign rsp.data = out_q;
  assign out_free = !out_v || rsp.ready;
  assign out_load = out_free && ((state == S_FIN && (!is_find || wr_ptr == '0))
                                 || state == S_OUTLD);
  assign is_find = (q.mode == rcc_pkg::MODE_FIND);
  assign nt = {1'b0, q.step_time} + 8'd1;
  assign ts = $signed({3'b000, nt}) + 11'(koff);
  assign ts_ok = (ts >= 0) && (int'(ts) < HORIZON);
  assign k_last = (koff == $signed({1'b0, q.delay_window}));
  assign edge_go = (q.delay_window == 3'd0) && (int'(nt) < HORIZON);
  assign place_match = (pl_rdata == {1'b1, q.location});
  assign abit = AGENTS'(1) << q.agent;

  always_comb begin
    low = '0;
    for (int i = AGENTS - 1; i >= 0; i--) begin
      if (scan_mask[i]) begin
        low = AW'(i);
      end
    end
  end

  always_comb begin
    emit_hit = 1'b0;
    emit_e = '0;
    unique case (state)
      S_VSCAN: begin
        emit_hit = 1'b1;
        emit_e.kind = rcc_pkg::KIND_VERTEX;
        emit_e.conflict_location = q.next_location;
        if (koff < 0) begin
          emit_e.first_agent = 5'(low);
          emit_e.second_agent = q.agent;
          emit_e.conflict_time = 8'(ts);
          emit_e.delay = 3'(-koff);
        end else begin
          emit_e.first_agent = q.agent;
          emit_e.second_agent = 5'(low);
          emit_e.conflict_time = nt;
          emit_e.delay = 3'(koff);
        end
      end
      S_GSCAN: begin
        emit_hit = goal_valid[ga] && (goal_loc[ga] == q.next_location)
                   && (nt > {1'b0, goal_time[ga]});
        emit_e.kind = rcc_pkg::KIND_GOAL;
        emit_e.first_agent = 5'(ga);
        emit_e.second_agent = q.agent;
        emit_e.conflict_location = q.next_location;
        emit_e.conflict_time = nt;
      end
      S_EPCHK: begin
        emit_hit = place_match;
        emit_e.kind = rcc_pkg::KIND_EDGE;
        emit_e.first_agent = q.agent;
        emit_e.second_agent = 5'(ea);
        emit_e.conflict_location = q.location;
        emit_e.edge_location = q.next_location;
        emit_e.conflict_time = nt;
      end
      default: begin
      end
    endcase
  end

  assign res_we = emit_hit && is_find && (int'(wr_ptr) < MAX_RESULTS);

  always_comb begin
    occ_raddr = '0;
    occ_we = 1'b0;
    occ_waddr = '0;
    occ_wdata = '0;
    pl_raddr = '0;
    pl_we = 1'b0;
    pl_waddr = '0;
    pl_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        occ_we = (int'(clr) < OCC_D);
        occ_waddr = clr[OCC_AW-1:0];
        pl_we = (int'(clr) < PL_D);
        pl_waddr = clr[PL_AW-1:0];
      end
      S_MRD: occ_raddr = occ_addr(q.location, {2'b00, mtime});
      S_MWR: begin
        occ_we = 1'b1;
        occ_waddr = occ_addr(q.location, {2'b00, mtime});
        occ_wdata = occ_rdata | abit;
        pl_we = 1'b1;
        pl_waddr = pl_addr(AW'(q.agent), {2'b00, mtime});
        pl_wdata = {1'b1, q.location};
      end
      S_RLRD: begin
        occ_raddr = occ_addr(q.location, {3'b000, q.step_time});
        pl_raddr = pl_addr(AW'(q.agent), {3'b000, q.step_time});
      end
      S_RLWR: begin
        occ_we = 1'b1;
        occ_waddr = occ_addr(q.location, {3'b000, q.step_time});
        occ_wdata = occ_rdata & ~abit;
        pl_we = place_match;
        pl_waddr = pl_addr(AW'(q.agent), {3'b000, q.step_time});
      end
      S_VRD: occ_raddr = occ_addr(q.next_location, 10'(ts));
      S_ERD: occ_raddr = occ_addr(q.next_location, {3'b000, q.step_time});
      S_EPRD: pl_raddr = pl_addr(low, {2'b00, nt});
      default: begin
      end
    endcase
  end

  rcc_ram #(.DW(AGENTS), .DEPTH(OCC_D), .ADW(OCC_AW)) u_occ (
    .clk(clk), .we(occ_we), .waddr(occ_waddr), .wdata(occ_wdata),
    .raddr(occ_raddr), .rdata(occ_rdata)
  );

  rcc_ram #(.DW(9), .DEPTH(PL_D), .ADW(PL_AW)) u_place (
    .clk(clk), .we(pl_we), .waddr(pl_waddr), .wdata(pl_wdata),
    .raddr(pl_raddr), .rdata(pl_rdata)
  );

  rcc_ram #(.DW(RES_W), .DEPTH(MAX_RESULTS), .ADW(RW)) u_res (
    .clk(clk), .we(res_we), .waddr(wr_ptr[RW-1:0]), .wdata(emit_e),
    .raddr(rd_ptr[RW-1:0]), .rdata(res_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      out_v <= 1'b0;
      hold_steps <= rcc_pkg::HOLD_STEPS_RESET;
      ignore_finished <= 1'b0;
      for (int i = 0; i < AGENTS; i++) begin
        goal_valid[i] <= 1'b0;
      end
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          rcc_pkg::CFG_HOLD_STEPS: hold_steps <= wr_data[3:0];
          rcc_pkg::CFG_IGNORE_FINISHED: ignore_finished <= wr_data[0];
          default: begin
          end
        endcase
      end
      out_v <= out_load || (out_v && !rsp.ready);
      if (res_we) begin
        wr_ptr <= wr_ptr + CW'(1);
      end
      if (emit_hit && is_find && !res_we) begin
        over <= 1'b1;
      end

      unique case (state)
        S_CLEAR: begin
          clr <= clr + CLW'(1);
          if (int'(clr) == CLR_D - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (acc) begin
            q <= req.data;
            mtime <= {1'b0, req.data.step_time};
            mleft <= req.data.malfunction ? hold_steps : 4'd0;
            koff <= -$signed({1'b0, req.data.delay_window});
            count <= '0;
            wr_ptr <= '0;
            over <= 1'b0;
            ga <= '0;
            if (req.data.mode == rcc_pkg::MODE_RESERVE
                || req.data.mode == rcc_pkg::MODE_RELEASE) begin
              if (int'(req.data.agent) < AGENTS && int'(req.data.location) < LOCATIONS
                  && int'(req.data.step_time) < HORIZON) begin
                if (req.data.mode == rcc_pkg::MODE_RESERVE) begin
                  state <= S_MRD;
                  if (req.data.path_end && !req.data.malfunction && !ignore_finished) begin
                    goal_valid[AW'(req.data.agent)] <= 1'b1;
                    goal_loc[AW'(req.data.agent)] <= req.data.location;
                    goal_time[AW'(req.data.agent)] <= req.data.step_time;
                  end
                end else begin
                  state <= S_RLRD;
                end
              end
            end else if (req.data.next_present
                         && int'(req.data.next_location) < LOCATIONS) begin
              state <= S_VRD;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_MRD: state <= S_MWR;
        S_MWR: begin
          if (mleft != 4'd0 && int'(mtime) + 1 < HORIZON) begin
            mtime <= mtime + 8'd1;
            mleft <= mleft - 4'd1;
            state <= S_MRD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_RLRD: state <= S_RLWR;
        S_RLWR: state <= S_IDLE;
        S_VRD: begin
          if (ts_ok) begin
            state <= S_VCHK;
          end else if (!k_last) begin
            koff <= koff + 4'sd1;
          end else begin
            state <= is_find ? S_GSCAN : (edge_go ? S_ERD : S_FIN);
          end
        end
        S_VCHK: begin
          scan_mask <= occ_rdata;
          if (occ_rdata != '0) begin
            if (count != 8'hff) begin
              count <= count + 8'd1;
            end
          end
          if (occ_rdata != '0 && is_find) begin
            state <= S_VSCAN;
          end else if (!k_last) begin
            koff <= koff + 4'sd1;
            state <= S_VRD;
          end else begin
            state <= is_find ? S_GSCAN : (edge_go ? S_ERD : S_FIN);
          end
        end
        S_VSCAN: begin
          scan_mask[low] <= 1'b0;
          if ((scan_mask & ~(AGENTS'(1) << low)) == '0) begin
            if (!k_last) begin
              koff <= koff + 4'sd1;
              state <= S_VRD;
            end else begin
              state <= S_GSCAN;
            end
          end
        end
        S_GSCAN: begin
          ga <= ga + AW'(1);
          if (int'(ga) == AGENTS - 1) begin
            state <= edge_go ? S_ERD : S_FIN;
          end
        end
        S_ERD: state <= S_ECHK;
        S_ECHK: begin
          scan_mask <= occ_rdata;
          state <= (occ_rdata == '0) ? S_FIN : S_EPRD;
        end
        S_EPRD: begin
          ea <= low;
          scan_mask[low] <= 1'b0;
          state <= S_EPCHK;
        end
        S_EPCHK: begin
          if (place_match && count != 8'hff) begin
            count <= count + 8'd1;
          end
          state <= (scan_mask == '0) ? S_FIN : S_EPRD;
        end
        S_FIN: begin
          if (!is_find || wr_ptr == '0) begin
            if (out_free) begin
              out_q <= {RES_W'(0), (q.mode == rcc_pkg::MODE_COUNT) ? count : 8'd0,
                        1'b0, 1'b1};
              state <= S_IDLE;
            end
          end else begin
            rd_ptr <= '0;
            state <= S_OUTRD;
          end
        end
        S_OUTRD: state <= S_OUTLD;
        S_OUTLD: begin
          if (out_free) begin
            out_q <= {res_rdata, 8'd0, over, (rd_ptr + CW'(1) == wr_ptr)};
            rd_ptr <= rd_ptr + CW'(1);
            state <= (rd_ptr + CW'(1) == wr_ptr) ? S_IDLE : S_OUTRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_not_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !req.ready)
    else $error("input accepted during clearing pass");

  a_emit_in_scan: assert property (@(posedge clk) disable iff (rst)
    res_we |-> (state == S_VSCAN || state == S_GSCAN || state == S_EPCHK))
    else $error("result buffer written outside a scan");

  a_count_is_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.data.conflict_count != 8'd0) |-> rsp.data.last)
    else $error("count result not marked last");

  a_buffer_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUTLD) |-> (rd_ptr < wr_ptr))
    else $error("result read beyond stored results");

endmodule
